>>> hw/rtl/idu_pkg.sv
package idu_pkg;

	// Default size of the keep-bit store.
	localparam int DEF_MAX_ELEMENTS = 4096;

	// Generator constants.
	localparam logic [31:0] LCG_MUL = 32'd1103515245;
	localparam logic [31:0] LCG_ADD = 32'd12345;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// Register map: index taken from paddr[3:2].
	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_TRAINING_ON = 2'd0;
	localparam logic [1:0] REG_DROP_LIMIT  = 2'd1;
	localparam logic [1:0] REG_KEEP_SCALE  = 2'd2;
	localparam logic [1:0] REG_START_SEED  = 2'd3;

	localparam logic [23:0] KEEP_SCALE_RESET = 24'd65536;

	// What the back does with an element.
	typedef enum logic [1:0] {
		OP_PASS,
		OP_DROP,
		OP_SCALE
	} op_t;

	typedef struct packed {
		logic        training_on;
		logic [15:0] drop_limit;
		logic [23:0] keep_scale;
		logic [31:0] start_seed;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] data;
	} entry_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             empty;
	} q_status_t;

endpackage

>>> hw/rtl/inverted_dropout_unit.sv
// Inverted dropout for a stream of Q16.16 tensor elements.
// Input stream s_*: one element per transaction. With training_on low or
// drop_limit zero, elements pass unchanged; otherwise forward items step a
// 32-bit linear congruential generator, compare a 15-bit draw with
// drop_limit, zero the element or scale it by keep_scale and store the keep
// bit at elem_index. Backward items scale a gradient by the stored keep bit.
// Output stream m_*: one result per input transaction, in input order.
// Registers are written over the APB port at 0x0 training_on, 0x4 drop_limit,
// 0x8 keep_scale, 0xC start_seed; the user must write them only while no
// element is in flight; the block does not enforce this. While m_tready is
// high, one element per cycle passes two front stages (generator step and
// keep-bit read, then operation choice and queue push) and two back stages
// (queue read and multiply, then round and saturate to the output register).
// Reset empties the pipeline, clears the generator and loads the register
// defaults. The keep-bit store is not cleared; a backward element whose index
// was never written by a forward element gives an undefined result.
// When m_tready is low the result holds in the output register; a four-entry
// queue between front and back absorbs elements in flight, and s_tready drops
// once four elements are held in the front stages and the queue.
module inverted_dropout_unit import idu_pkg::*; #(
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [47:0]        s_tdata,  // elem_index[11:0], data_in[43:12], zero[47:44]
	input  logic [1:0]         s_tuser,  // req_type[0], restart[1]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,  // data_out[31:0]
	output logic [0:0]         m_tuser,  // kept[0]
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t      cfg_q;
	q_status_t q_status;
	logic      push;
	entry_t    push_entry;
	logic      pop;
	entry_t    pop_entry;
	logic      cfg_wr;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.training_on <= 1'b0;
			cfg_q.drop_limit  <= 16'd0;
			cfg_q.keep_scale  <= KEEP_SCALE_RESET;
			cfg_q.start_seed  <= 32'd0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_TRAINING_ON: cfg_q.training_on <= pwdata[0];
				REG_DROP_LIMIT:  cfg_q.drop_limit  <= pwdata[15:0];
				REG_KEEP_SCALE:  cfg_q.keep_scale  <= pwdata[23:0];
				REG_START_SEED:  cfg_q.start_seed  <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TRAINING_ON: prdata = {31'd0, cfg_q.training_on};
			REG_DROP_LIMIT:  prdata = {16'd0, cfg_q.drop_limit};
			REG_KEEP_SCALE:  prdata = {8'd0, cfg_q.keep_scale};
			REG_START_SEED:  prdata = cfg_q.start_seed;
		endcase
	end

	idu_front #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_status  (q_status),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push      (push),
		.push_entry(push_entry)
	);

	idu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.pop_entry (pop_entry),
		.status    (q_status)
	);

	idu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_status (q_status),
		.pop_entry(pop_entry),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// The front never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_status.count < CNT_W'(QUEUE_DEPTH)) || pop)
		else $error("queue overflow");

	// The back never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("queue underflow");

	// A dropped element always comes out as zero.
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0))
		else $error("dropped element is not zero");

endmodule

>>> hw/rtl/idu_front.sv
module idu_front import idu_pkg::*; #(
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  q_status_t   q_status,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [1:0]  s_tuser,
	output logic        push,
	output entry_t      push_entry
);

	localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam logic [31:0] MAX_W = 32'(MAX_ELEMENTS);

	logic        v_s1;
	logic        bwd_s1;
	logic        restart_s1;
	logic [11:0] idx_s1;
	logic [31:0] data_s1;

	logic        v_s2;
	logic        need_mask_s2;
	logic        in_store_s2;
	logic        mask_s2;
	op_t         op_s2;
	logic [31:0] data_s2;

	logic [31:0] lcg_q;
	logic        mask_mem [MAX_ELEMENTS];

	logic [3:0]  occupancy;
	logic        accept;
	logic        bypass;
	logic        in_store;
	logic [AW-1:0] addr_s1;
	logic [31:0] lcg_base;
	logic [31:0] lcg_step;
	logic        drop;
	op_t         op_s1;

	// Accept only while every item in flight is sure of a queue slot.
	assign occupancy = 4'(q_status.count) + 4'(v_s1) + 4'(v_s2);
	assign s_tready  = occupancy < 4'(QUEUE_DEPTH);
	assign accept    = s_tvalid && s_tready;

	// Stage 1 capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bwd_s1     <= s_tuser[0];
			restart_s1 <= s_tuser[1];
			idx_s1     <= s_tdata[11:0];
			data_s1    <= s_tdata[43:12];
		end
	end

	// Classification and the generator step.
	assign bypass   = !cfg.training_on || (cfg.drop_limit == 16'd0);
	assign in_store = {20'd0, idx_s1} < MAX_W;
	assign addr_s1  = AW'(idx_s1);
	assign lcg_base = restart_s1 ? cfg.start_seed : lcg_q;
	assign lcg_step = lcg_base * LCG_MUL + LCG_ADD;
	assign drop     = {1'b0, lcg_step[30:16]} < cfg.drop_limit;

	always_comb begin
		if (bypass) begin
			op_s1 = OP_PASS;
		end else if (bwd_s1) begin
			op_s1 = OP_DROP;
		end else if (drop) begin
			op_s1 = OP_DROP;
		end else begin
			op_s1 = OP_SCALE;
		end
	end

	// The generator moves on forward items only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q <= 32'd0;
		end else if (v_s1 && !bwd_s1) begin
			lcg_q <= bypass ? lcg_base : lcg_step;
		end
	end

	// Keep-bit store: forward items outside bypass write, backward items read into stage 2.
	always_ff @(posedge clk) begin
		if (v_s1 && !bwd_s1 && !bypass && in_store) begin
			mask_mem[addr_s1] <= !drop;
		end
		if (v_s1) begin
			mask_s2 <= mask_mem[addr_s1];
		end
	end

	// Stage 2 capture.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			need_mask_s2 <= bwd_s1 && !bypass;
			in_store_s2  <= in_store;
			op_s2        <= op_s1;
			data_s2      <= data_s1;
		end
	end

	// A backward item learns its operation from the stored keep bit.
	always_comb begin
		push            = v_s2;
		push_entry.data = data_s2;
		if (need_mask_s2) begin
			push_entry.op = (in_store_s2 && mask_s2) ? OP_SCALE : OP_DROP;
		end else begin
			push_entry.op = op_s2;
		end
	end

endmodule

>>> hw/rtl/idu_queue.sv
module idu_queue import idu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  entry_t    push_entry,
	input  logic      pop,
	output entry_t    pop_entry,
	output q_status_t status
);

	entry_t            slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign pop_entry    = slots_q[rd_ptr_q];
	assign status.count = count_q;
	assign status.empty = (count_q == '0);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

>>> hw/rtl/idu_back.sv
module idu_back import idu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  q_status_t   q_status,
	input  entry_t      pop_entry,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic [0:0]  m_tuser
);

	logic               v_s3;
	op_t                op_s3;
	logic [31:0]        data_s3;
	logic signed [56:0] prod_s3;

	logic               out_v_q;
	logic [31:0]        out_data_q;
	logic               out_kept_q;

	logic               en_out;
	logic               en_s3;
	logic signed [56:0] rounded;
	logic [40:0]        quot;
	logic [31:0]        sat_val;
	logic [31:0]        res_data;
	logic               res_kept;

	// Stall chain from the output register back to the queue.
	assign en_out = !out_v_q || m_tready;
	assign en_s3  = !v_s3 || en_out;
	assign pop    = en_s3 && !q_status.empty;

	// Multiply stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s3   <= pop_entry.op;
			data_s3 <= pop_entry.data;
			prod_s3 <= 57'($signed(pop_entry.data) * $signed({1'b0, cfg.keep_scale}));
		end
	end

	// Round half up, drop sixteen fraction bits and saturate.
	assign rounded = prod_s3 + 57'sd32768;
	assign quot    = rounded[56:16];

	always_comb begin
		if (quot[40:31] == {10{quot[40]}}) begin
			sat_val = quot[31:0];
		end else if (quot[40]) begin
			sat_val = 32'h8000_0000;
		end else begin
			sat_val = 32'h7fff_ffff;
		end
	end

	always_comb begin
		unique case (op_s3)
			OP_PASS: begin
				res_data = data_s3;
				res_kept = 1'b1;
			end
			OP_SCALE: begin
				res_data = sat_val;
				res_kept = 1'b1;
			end
			OP_DROP: begin
				res_data = 32'd0;
				res_kept = 1'b0;
			end
			default: begin
				res_data = 32'd0;
				res_kept = 1'b0;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s3) begin
			out_data_q <= res_data;
			out_kept_q <= res_kept;
		end
	end

	assign m_tvalid   = out_v_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_kept_q;

endmodule

>>> tb/sv/tb_inverted_dropout_unit.sv
module tb_inverted_dropout_unit import idu_pkg::*; ();

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_SLACK = 8;
	localparam int HOLD_CYCLES = 60;
	localparam int ITEMS_PER_PHASE = 325;
	localparam int DIR_ROWS = 31;
	localparam int STORE_SIZE = DEF_MAX_ELEMENTS;
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -SAT_HI - 1;

	typedef enum logic {REQ_FWD, REQ_BWD} req_t;
	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// One row of the directed part: either a register write or an element.
	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  reg_sel;
		logic [31:0] reg_value;
		req_t        rtype;
		logic [11:0] idx;
		logic        restart;
		logic [31:0] data;
		logic        typed;
		logic [31:0] exp_data;
		logic        exp_kept;
	} stim_row_t;

	typedef struct packed {
		logic [31:0] data;
		logic        kept;
	} result_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [47:0]        s_tdata;  // elem_index[11:0], data_in[43:12], zero[47:44]
	logic [1:0]         s_tuser;  // req_type[0], restart[1]
	logic               m_tvalid;
	logic               m_tready;
	logic [31:0]        m_tdata;  // data_out[31:0]
	logic [0:0]         m_tuser;  // kept[0]
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	// Expectation typed into the directed table travels beside the transaction.
	logic        cur_typed;
	logic [31:0] cur_typed_data;
	logic        cur_typed_kept;

	// Shadow of the registers and of the block's state.
	logic        cfg_training = 1'b0;
	logic [15:0] cfg_limit = 16'd0;
	logic [23:0] cfg_scale = KEEP_SCALE_RESET;
	logic [31:0] cfg_seed = 32'd0;
	logic [31:0] gen_state = 32'd0;
	logic        keep_mask [STORE_SIZE];
	bit          mask_written [STORE_SIZE];
	logic [11:0] written_list [$];

	result_t pending_results [$];
	int      fail_cnt = 0;
	int      cycle_cnt = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	bit      hold_trigger = 1'b0;

	stim_row_t directed_rows [DIR_ROWS] = '{
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'h000, 1'b0, 32'h7fffffff,
			1'b1, 32'h7fffffff, 1'b1},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'hfff, 1'b1, 32'h80000000,
			1'b1, 32'h80000000, 1'b1},
		'{ROW_CFG, REG_TRAINING_ON, 32'h1, REQ_FWD, 12'h0, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'h000, 1'b0, 32'h00010000,
			1'b1, 32'h00010000, 1'b1},
		'{ROW_CFG, REG_DROP_LIMIT, 32'h4000, REQ_FWD, 12'h0, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{ROW_CFG, REG_KEEP_SCALE, 32'h20000, REQ_FWD, 12'h0, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{ROW_CFG, REG_START_SEED, 32'h12345678, REQ_FWD, 12'h0, 1'b0, 32'h0, 1'b0, 32'h0,
			1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'h000, 1'b1, 32'h00010000,
			1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'hfff, 1'b0, 32'h7fffffff,
			1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'h001, 1'b0, 32'h80000000,
			1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'h002, 1'b0, 32'hffffffff,
			1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'h003, 1'b0, 32'h00000001,
			1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_BWD, 12'h000, 1'b0, 32'h00018000,
			1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_BWD, 12'hfff, 1'b0, 32'h7fffffff,
			1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_BWD, 12'h001, 1'b0, 32'h80000000,
			1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_BWD, 12'h002, 1'b1, 32'h12345678,
			1'b0, 32'h0, 1'b0},
		'{ROW_CFG, REG_DROP_LIMIT, 32'h8000, REQ_FWD, 12'h0, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'h004, 1'b0, 32'h7fffffff,
			1'b1, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_BWD, 12'h004, 1'b0, 32'h7fffffff,
			1'b1, 32'h0, 1'b0},
		'{ROW_CFG, REG_DROP_LIMIT, 32'h1, REQ_FWD, 12'h0, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{ROW_CFG, REG_KEEP_SCALE, 32'hffffff, REQ_FWD, 12'h0, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'h005, 1'b1, 32'h7fffffff,
			1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'h006, 1'b0, 32'h80000000,
			1'b0, 32'h0, 1'b0},
		'{ROW_CFG, REG_KEEP_SCALE, 32'h8000, REQ_FWD, 12'h0, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'h007, 1'b0, 32'h00000001,
			1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'h008, 1'b0, 32'hffffffff,
			1'b0, 32'h0, 1'b0},
		'{ROW_CFG, REG_KEEP_SCALE, 32'h0, REQ_FWD, 12'h0, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'h009, 1'b0, 32'h12345678,
			1'b0, 32'h0, 1'b0},
		'{ROW_CFG, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'h0, 1'b0, 32'h0, 1'b0, 32'h0, 1'b0},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_BWD, 12'h004, 1'b0, 32'h80000000,
			1'b1, 32'h80000000, 1'b1},
		'{ROW_ITEM, REG_TRAINING_ON, 32'h0, REQ_FWD, 12'h00a, 1'b1, 32'h7fffffff,
			1'b1, 32'h7fffffff, 1'b1}
	};

	inverted_dropout_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Clock with a period of eight units.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Survivor gain: exact product, round half up, saturate to 32 bits.
	function automatic logic [31:0] apply_gain(logic [31:0] raw, logic [23:0] gain);
		longint prod;
		longint q;
		prod = longint'(signed'(raw)) * longint'({8'd0, gain});
		q = (prod + 64'sd32768) >>> 16;
		if (q > SAT_HI) q = SAT_HI;
		if (q < SAT_LO) q = SAT_LO;
		return q[31:0];
	endfunction

	// Expected result of one element; advances the generator and the keep bits.
	function automatic void dropout_predict(input req_t rtype, input logic [11:0] idx,
			input logic restart, input logic [31:0] din,
			output logic [31:0] dout, output logic kept);
		logic bypass;
		logic [14:0] draw;
		bypass = !cfg_training || (cfg_limit == 16'd0);
		if (bypass) begin
			dout = din;
			kept = 1'b1;
			if (rtype == REQ_FWD && restart) gen_state = cfg_seed;
		end else if (rtype == REQ_FWD) begin
			if (restart) gen_state = cfg_seed;
			gen_state = gen_state * LCG_MUL + LCG_ADD;
			draw = gen_state[30:16];
			kept = ({1'b0, draw} >= cfg_limit);
			dout = kept ? apply_gain(din, cfg_scale) : 32'd0;
			keep_mask[idx] = kept;
			if (!mask_written[idx]) begin
				mask_written[idx] = 1'b1;
				written_list.push_back(idx);
			end
		end else begin
			kept = keep_mask[idx];
			dout = kept ? apply_gain(din, cfg_scale) : 32'd0;
		end
	endfunction

	function automatic logic [31:0] random_value();
		case ($urandom_range(7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(32'h3ffff);
			3: return 32'h0 - $urandom_range(32'h3ffff);
			default: return $urandom;
		endcase
	endfunction

	// Offer one element after a random gap and wait for its transaction.
	task automatic send_item(req_t rtype, logic [11:0] idx, logic restart, logic [31:0] din,
			logic typed, logic [31:0] typed_data, logic typed_kept);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, din, idx};
		s_tuser <= {restart, rtype};
		cur_typed <= typed;
		cur_typed_data <= typed_data;
		cur_typed_kept <= typed_kept;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle.
	task automatic write_register(logic [1:0] reg_sel, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Track register writes and accepted elements, queueing the expected results.
	always @(posedge clk) begin
		if (arst_n) begin : track
			logic [31:0] dout;
			logic kept;
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_TRAINING_ON: cfg_training = pwdata[0];
					REG_DROP_LIMIT:  cfg_limit = pwdata[15:0];
					REG_KEEP_SCALE:  cfg_scale = pwdata[23:0];
					REG_START_SEED:  cfg_seed = pwdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				dropout_predict(req_t'(s_tuser[0]), s_tdata[11:0], s_tuser[1],
					s_tdata[43:12], dout, kept);
				if (cur_typed)
					pending_results.push_back('{cur_typed_data, cur_typed_kept});
				else
					pending_results.push_back('{dout, kept});
			end
		end
	end

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin : compare
			result_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result: data_out %h kept %b", m_tdata, m_tuser[0]);
				fail_cnt++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata !== want.data) begin
					$error("data_out: expected %h, actual %h", want.data, m_tdata);
					fail_cnt++;
				end
				if (m_tuser[0] !== want.kept) begin
					$error("kept: expected %b, actual %b", want.kept, m_tuser[0]);
					fail_cnt++;
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : receiver
		int c;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_trigger) begin
				hold_trigger = 1'b0;
				m_tready <= 1'b0;
				for (c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Stimulus: directed table, then four random phases with different settings.
	initial begin : stimulus
		int r;
		int ph;
		int n;
		stim_row_t row;
		req_t rtype;
		logic [11:0] idx;
		logic restart;
		logic [31:0] set_training;
		logic [31:0] set_limit;
		logic [31:0] set_scale;
		logic [31:0] set_seed;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cur_typed = 1'b0;
		cur_typed_data = '0;
		cur_typed_kept = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		foreach (keep_mask[i]) keep_mask[i] = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, light idling on both sides.
		send_idle_pct = 29;
		recv_stall_pct = 29;
		for (r = 0; r < DIR_ROWS; r++) begin
			row = directed_rows[r];
			if (row.kind == ROW_CFG) begin
				drain_results();
				write_register(row.reg_sel, row.reg_value);
			end else begin
				send_item(row.rtype, row.idx, row.restart, row.data, row.typed,
					row.exp_data, row.exp_kept);
			end
		end

		// Random phases.
		for (ph = 0; ph < 4; ph++) begin
			drain_results();
			set_training = 32'(ph != 2);
			set_limit = $urandom_range(1, 32767);
			set_scale = $urandom_range(0, 24'hffffff);
			set_seed = $urandom;
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					set_limit = 32'h4000;
					set_scale = 32'h20000;
					set_seed = 32'hffffffff;
					send_idle_pct = 81;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 81;
				end
				default: begin
					set_scale = 32'hffffff;
					set_seed = 32'h0;
					send_idle_pct = 29;
					recv_stall_pct = 29;
				end
			endcase
			write_register(REG_TRAINING_ON, set_training);
			write_register(REG_DROP_LIMIT, set_limit);
			write_register(REG_KEEP_SCALE, set_scale);
			write_register(REG_START_SEED, set_seed);

			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Back-pressure test: long receiver hold, then a full pause.
				if (ph == 0 && n == 100) hold_trigger = 1'b1;
				if (ph == 0 && n == 200) drain_results();
				if (written_list.size() != 0 && $urandom_range(99) < 40) begin
					rtype = REQ_BWD;
					idx = written_list[$urandom_range(written_list.size() - 1)];
					restart = 1'($urandom_range(1));
				end else begin
					rtype = REQ_FWD;
					idx = ($urandom_range(99) < 30) ? 12'($urandom_range(31)) :
						12'($urandom_range(4095));
					restart = ($urandom_range(99) < 5);
				end
				send_item(rtype, idx, restart, random_value(), 1'b0, 32'd0, 1'b0);
			end
		end

		drain_results();
		if (fail_cnt == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/idu_pkg.sv
hw/rtl/idu_front.sv
hw/rtl/idu_queue.sv
hw/rtl/idu_back.sv
hw/rtl/inverted_dropout_unit.sv
tb/sv/tb_inverted_dropout_unit.sv
